[hw/rtl/ogf_pkg.sv]
// ----------------------------------------------------------------------------
// ogf_pkg
// Shared types, register indexes and constants of the occupancy grid fusion
// block.
// ----------------------------------------------------------------------------
package ogf_pkg;

  localparam int GRID_DIM_DEF  = 512;
  localparam int LOCAL_DIM_DEF = 128;

  // address fields in the command carry the widest legal grid and costmap
  localparam int LADDR_W = 20;
  localparam int GADDR_W = 24;
  localparam int PROD_W  = 53;

  typedef enum logic [1:0] {
    FN_POSE = 2'd0,
    FN_CELL = 2'd1,
    FN_TICK = 2'd2,
    FN_READ = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_POSE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  localparam logic [2:0] REG_MOVE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_LOCAL_WIDTH    = 3'd1;
  localparam logic [2:0] REG_LOCAL_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_LOCAL_ORIGIN_X = 3'd3;
  localparam logic [2:0] REG_LOCAL_ORIGIN_Y = 3'd4;
  localparam logic [2:0] REG_LOCAL_CELL_SZ  = 3'd5;
  localparam logic [2:0] REG_GRID_CPM       = 3'd6;
  localparam logic [2:0] REG_GRID_ORIGIN    = 3'd7;

  localparam logic [15:0]        RST_MOVE_THRESHOLD = 16'd384;
  localparam logic [7:0]         RST_LOCAL_WIDTH    = 8'd128;
  localparam logic [7:0]         RST_LOCAL_HEIGHT   = 8'd128;
  localparam logic signed [23:0] RST_LOCAL_ORIGIN   = -24'sd1638;
  localparam logic [15:0]        RST_LOCAL_CELL_SZ  = 16'd6554;
  localparam logic [15:0]        RST_GRID_CPM       = 16'd1280;
  localparam logic signed [23:0] RST_GRID_ORIGIN    = -24'sd13107;

  localparam logic [7:0] COST_UNKNOWN = 8'hFF;

  typedef struct packed {
    func_t              func;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [7:0]  cell_cost;
    logic [6:0]         local_col;
    logic [6:0]         local_row;
    logic               cell_last;
    logic [8:0]         grid_col;
    logic [8:0]         grid_row;
  } in_t;

  typedef struct packed {
    kind_t             kind;
    logic              moved;
    logic              integrated;
    logic [14:0]       cells_written;
    logic signed [7:0] read_value;
  } out_t;

  typedef struct packed {
    func_t               op;
    logic signed [23:0]  pos_x;
    logic signed [23:0]  pos_y;
    logic [7:0]          cost;
    logic [LADDR_W-1:0]  laddr;
    logic                lok;
    logic                last;
    logic [GADDR_W-1:0]  gaddr;
    logic                gok;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POSE0,
    ST_POSE1,
    ST_POSE2,
    ST_POSE3,
    ST_RD_WAIT,
    ST_TICK0,
    ST_TICK1,
    ST_TICK2,
    ST_TICK3,
    ST_ROW,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_TDONE,
    ST_EMIT
  } bk_state_t;

endpackage

[hw/rtl/ogf_ram.sv]
// ----------------------------------------------------------------------------
// ogf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ogf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ogf_fifo.sv]
// ----------------------------------------------------------------------------
// ogf_fifo
// Two-entry register queue used between the front and the back and on the
// result side.
// ----------------------------------------------------------------------------
module ogf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

[hw/rtl/ogf_front.sv]
// ----------------------------------------------------------------------------
// ogf_front
// Accepts input beats, decodes them into commands with range checks and
// flat memory addresses, and queues them for the back end.
// ----------------------------------------------------------------------------
module ogf_front #(
  parameter int GRID_DIM  = ogf_pkg::GRID_DIM_DEF,
  parameter int LOCAL_DIM = ogf_pkg::LOCAL_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  ogf_pkg::in_t  in_data,
  output logic          in_full,
  input  logic          hold,
  input  logic          cmd_pop,
  output logic          cmd_empty,
  output ogf_pkg::cmd_t cmd_head
);
  import ogf_pkg::*;

  cmd_t                cmd;
  logic                q_full;
  logic                accept;
  logic [$bits(cmd_t)-1:0] q_dout;

  assign in_full = q_full || hold;
  assign accept  = in_push && !in_full;

  always_comb begin
    cmd.op    = in_data.func;
    cmd.pos_x = in_data.pos_x;
    cmd.pos_y = in_data.pos_y;
    cmd.cost  = in_data.cell_cost;
    cmd.last  = in_data.cell_last;
    cmd.lok   = (int'(in_data.local_col) < LOCAL_DIM) && (int'(in_data.local_row) < LOCAL_DIM);
    cmd.laddr = LADDR_W'(int'(in_data.local_row) * LOCAL_DIM + int'(in_data.local_col));
    cmd.gok   = (int'(in_data.grid_col) < GRID_DIM) && (int'(in_data.grid_row) < GRID_DIM);
    cmd.gaddr = GADDR_W'(int'(in_data.grid_row) * GRID_DIM + int'(in_data.grid_col));
  end

  ogf_fifo #(.WIDTH($bits(cmd_t))) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (cmd),
    .full  (q_full),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (q_dout)
  );

  assign cmd_head = cmd_t'(q_dout);

endmodule

[hw/rtl/ogf_back.sv]
// ----------------------------------------------------------------------------
// ogf_back
// Sequencer that carries out queued commands: pose threshold check, costmap
// writes, grid reads and the costmap-to-grid integration walk. Holds the
// configuration registers and both memories.
// ----------------------------------------------------------------------------
module ogf_back #(
  parameter int GRID_DIM  = ogf_pkg::GRID_DIM_DEF,
  parameter int LOCAL_DIM = ogf_pkg::LOCAL_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [23:0]   cfg_wdata,
  input  logic          cmd_empty,
  input  ogf_pkg::cmd_t cmd_head,
  output logic          cmd_pop,
  output logic          clearing,
  output logic          res_push,
  output ogf_pkg::out_t res_data,
  input  logic          res_full
);
  import ogf_pkg::*;

  localparam int GCELLS = GRID_DIM * GRID_DIM;
  localparam int GAW    = $clog2(GCELLS);
  localparam int GIW    = $clog2(GRID_DIM);
  localparam int LCELLS = LOCAL_DIM * LOCAL_DIM;
  localparam int LAW    = $clog2(LCELLS);
  localparam int LIW    = $clog2(LOCAL_DIM);
  localparam int LCW    = $clog2(LOCAL_DIM + 1);

  bk_state_t state_r, state_nxt;

  logic [15:0]        thr_r;
  logic [7:0]         lw_r;
  logic [7:0]         lh_r;
  logic signed [23:0] lox_r;
  logic signed [23:0] loy_r;
  logic [15:0]        cs_r;
  logic [15:0]        cpm_r;
  logic signed [23:0] go_r;

  logic signed [23:0] robot_x_r, robot_y_r, anchor_x_r, anchor_y_r;
  logic               have_local_r, pending_r;
  logic [GAW-1:0]     clr_r;

  logic [49:0]               sq_r;
  logic [50:0]               d2_r;
  logic signed [42:0]        mul_r;
  logic signed [PROD_W-1:0]  basex_r, prodx_r, prody_r, step_r;
  logic [LIW-1:0]            row_r, col_r;
  logic [LCW-1:0]            w_r, h_r;
  logic [GAW-1:0]            rowbase_r, gaddr_r;
  logic                      myok_r, mxok_r;
  logic [14:0]               count_r;
  out_t                      res_r;
  logic                      cmd_ok_r;

  logic signed [24:0] dx, dy, sq_in;
  logic signed [49:0] sq_prod;
  logic signed [25:0] bx, by, mul_a;
  logic signed [16:0] mul_b;
  logic signed [42:0] mul_prod;
  logic [LCW-1:0]     w_clamp, h_clamp;
  logic               myok, mxok;
  logic               col_last, row_last;
  logic               moved;

  logic             grid_we;
  logic [GAW-1:0]   grid_waddr, grid_raddr;
  logic [7:0]       grid_wdata, grid_rdata;
  logic             local_we;
  logic [LAW-1:0]   local_waddr, local_raddr;
  logic [7:0]       local_rdata;

  assign dx       = 25'(robot_x_r) - 25'(anchor_x_r);
  assign dy       = 25'(robot_y_r) - 25'(anchor_y_r);
  assign sq_prod  = sq_in * sq_in;
  assign bx       = 26'(robot_x_r) + 26'(lox_r) - 26'(go_r);
  assign by       = 26'(robot_y_r) + 26'(loy_r) - 26'(go_r);
  assign mul_b    = $signed({1'b0, cpm_r});
  assign mul_prod = mul_a * mul_b;
  assign w_clamp  = (int'(lw_r) > LOCAL_DIM) ? LCW'(LOCAL_DIM) : LCW'(lw_r);
  assign h_clamp  = (int'(lh_r) > LOCAL_DIM) ? LCW'(LOCAL_DIM) : LCW'(lh_r);
  assign myok     = !prody_r[PROD_W-1] && (int'(prody_r[PROD_W-1:24]) < GRID_DIM);
  assign mxok     = !prodx_r[PROD_W-1] && (int'(prodx_r[PROD_W-1:24]) < GRID_DIM);
  assign col_last = (LCW'(col_r) + LCW'(1)) == w_r;
  assign row_last = (LCW'(row_r) + LCW'(1)) == h_r;
  assign moved    = {1'b0, d2_r} >= {2'b0, sq_r};
  assign clearing = (state_r == ST_CLEAR);
  assign res_data = res_r;

  always_comb begin
    sq_in = '0;
    mul_a = '0;
    case (state_r)
      ST_POSE0: sq_in = dx;
      ST_POSE1: sq_in = dy;
      ST_POSE2: sq_in = $signed({9'd0, thr_r});
      ST_TICK0: mul_a = bx;
      ST_TICK1: mul_a = by;
      ST_TICK2: mul_a = $signed({10'd0, cs_r});
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    grid_we     = 1'b0;
    grid_waddr  = gaddr_r;
    grid_wdata  = local_rdata;
    grid_raddr  = '0;
    local_we    = 1'b0;
    local_waddr = cmd_head.laddr[LAW-1:0];
    local_raddr = LAW'(int'(row_r) * LOCAL_DIM + int'(col_r));
    case (state_r)
      ST_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_r;
        grid_wdata = COST_UNKNOWN;
        if (clr_r == GAW'(GCELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd_head.op)
            FN_POSE: state_nxt = ST_POSE0;
            FN_CELL: local_we = cmd_head.lok;
            FN_TICK: state_nxt = (pending_r && have_local_r) ? ST_TICK0 : ST_EMIT;
            FN_READ: begin
              grid_raddr = cmd_head.gaddr[GAW-1:0];
              state_nxt  = ST_RD_WAIT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POSE0:   state_nxt = ST_POSE1;
      ST_POSE1:   state_nxt = ST_POSE2;
      ST_POSE2:   state_nxt = ST_POSE3;
      ST_POSE3:   state_nxt = ST_EMIT;
      ST_RD_WAIT: state_nxt = ST_EMIT;
      ST_TICK0:   state_nxt = ST_TICK1;
      ST_TICK1:   state_nxt = ST_TICK2;
      ST_TICK2:   state_nxt = ST_TICK3;
      ST_TICK3:   state_nxt = (w_clamp == '0 || h_clamp == '0) ? ST_TDONE : ST_ROW;
      ST_ROW:     state_nxt = ST_CELL_RD;
      ST_CELL_RD: state_nxt = ST_CELL_WR;
      ST_CELL_WR: begin
        grid_we = !local_rdata[7] && myok_r && mxok_r;
        if (!col_last) begin
          state_nxt = ST_CELL_RD;
        end else if (!row_last) begin
          state_nxt = ST_ROW;
        end else begin
          state_nxt = ST_TDONE;
        end
      end
      ST_TDONE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        res_push = !res_full;
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      thr_r        <= RST_MOVE_THRESHOLD;
      lw_r         <= RST_LOCAL_WIDTH;
      lh_r         <= RST_LOCAL_HEIGHT;
      lox_r        <= RST_LOCAL_ORIGIN;
      loy_r        <= RST_LOCAL_ORIGIN;
      cs_r         <= RST_LOCAL_CELL_SZ;
      cpm_r        <= RST_GRID_CPM;
      go_r         <= RST_GRID_ORIGIN;
      robot_x_r    <= '0;
      robot_y_r    <= '0;
      anchor_x_r   <= '0;
      anchor_y_r   <= '0;
      have_local_r <= 1'b0;
      pending_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + GAW'(1);
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_MOVE_THRESHOLD: thr_r <= cfg_wdata[15:0];
          REG_LOCAL_WIDTH:    lw_r  <= cfg_wdata[7:0];
          REG_LOCAL_HEIGHT:   lh_r  <= cfg_wdata[7:0];
          REG_LOCAL_ORIGIN_X: lox_r <= $signed(cfg_wdata);
          REG_LOCAL_ORIGIN_Y: loy_r <= $signed(cfg_wdata);
          REG_LOCAL_CELL_SZ:  cs_r  <= cfg_wdata[15:0];
          REG_GRID_CPM:       cpm_r <= cfg_wdata[15:0];
          REG_GRID_ORIGIN:    go_r  <= $signed(cfg_wdata);
          default: begin
          end
        endcase
      end
      if (state_r == ST_IDLE && !cmd_empty) begin
        if (cmd_head.op == FN_POSE) begin
          robot_x_r <= cmd_head.pos_x;
          robot_y_r <= cmd_head.pos_y;
        end
        if (cmd_head.op == FN_CELL && cmd_head.last) begin
          have_local_r <= 1'b1;
          if (!have_local_r) begin
            pending_r <= 1'b1;
          end
        end
      end
      if (state_r == ST_POSE3 && moved) begin
        pending_r  <= 1'b1;
        anchor_x_r <= robot_x_r;
        anchor_y_r <= robot_y_r;
      end
      if (state_r == ST_TDONE) begin
        pending_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_r  <= 50'(sq_prod);
    mul_r <= mul_prod;
    case (state_r)
      ST_IDLE: begin
        res_r <= '0;
        case (cmd_head.op)
          FN_TICK: res_r.kind <= KIND_TICK;
          FN_READ: res_r.kind <= KIND_READ;
          default: res_r.kind <= KIND_POSE;
        endcase
      end
      ST_POSE1: d2_r <= {1'b0, sq_r};
      ST_POSE2: d2_r <= d2_r + {1'b0, sq_r};
      ST_POSE3: res_r.moved <= moved;
      ST_RD_WAIT: begin
        res_r.read_value <= cmd_ok_r ? $signed(grid_rdata) : $signed(COST_UNKNOWN);
      end
      ST_TICK1: basex_r <= {{2{mul_r[42]}}, mul_r, 8'd0};
      ST_TICK2: prody_r <= {{2{mul_r[42]}}, mul_r, 8'd0};
      ST_TICK3: begin
        step_r  <= PROD_W'(mul_r);
        prodx_r <= basex_r;
        row_r   <= '0;
        col_r   <= '0;
        w_r     <= w_clamp;
        h_r     <= h_clamp;
        count_r <= '0;
      end
      ST_ROW: begin
        myok_r    <= myok;
        rowbase_r <= GAW'(int'(prody_r[24 +: GIW]) * GRID_DIM);
        col_r     <= '0;
        prodx_r   <= basex_r;
      end
      ST_CELL_RD: begin
        mxok_r  <= mxok;
        gaddr_r <= rowbase_r + GAW'(prodx_r[24 +: GIW]);
      end
      ST_CELL_WR: begin
        if (!local_rdata[7] && myok_r && mxok_r && count_r != '1) begin
          count_r <= count_r + 15'd1;
        end
        if (!col_last) begin
          col_r   <= col_r + LIW'(1);
          prodx_r <= prodx_r + step_r;
        end else begin
          row_r   <= row_r + LIW'(1);
          prody_r <= prody_r + step_r;
        end
      end
      ST_TDONE: begin
        res_r.integrated    <= 1'b1;
        res_r.cells_written <= count_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      cmd_ok_r <= cmd_head.gok;
    end
  end

  ogf_ram #(.WIDTH(8), .DEPTH(GCELLS)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  ogf_ram #(.WIDTH(8), .DEPTH(LCELLS)) u_local (
    .clk   (clk),
    .we    (local_we),
    .waddr (local_waddr),
    .wdata (cmd_head.cost),
    .raddr (local_raddr),
    .rdata (local_rdata)
  );

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == ST_IDLE))
    else $error("command taken outside idle");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");
  a_grid_we: assert property (@(posedge clk) disable iff (!rst_n)
    grid_we |-> (state_r == ST_CLEAR || state_r == ST_CELL_WR))
    else $error("grid written outside clear or integration");
  a_local_we: assert property (@(posedge clk) disable iff (!rst_n)
    local_we |-> (state_r == ST_IDLE && cmd_head.op == FN_CELL))
    else $error("costmap written without a cell command");
  a_pending_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TDONE) |=> !pending_r)
    else $error("pending flag survived integration");
`endif

endmodule

[hw/rtl/occupancy_grid_costmap_fusion_core.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_costmap_fusion_core
// Occupancy grid with costmap fusion: a front end decodes and queues input
// beats, a back end sequencer executes them against the grid and costmap.
// ----------------------------------------------------------------------------
// usage
//   input: drive in_data and raise in_push; the beat is taken when in_full is
//   low. results: while out_empty is low out_data holds the oldest result,
//   raise out_pop to take it. cfg_we writes cfg_wdata into register cfg_idx
//   at once; the user must write only while the block is idle, which the
//   block itself does not enforce. a command queue of two beats parts the
//   front from the back, and a result queue of two beats parts the back
//   from the receiver, so a stalled receiver stops the back only once its
//   queue is full. the back sequencer works one item at a time and takes
//   no new command until it is done with the last; an integrating tick
//   walks the w by h cells of the costmap size in use, row by row, each
//   with its registered ram read. the earliest pop of a result comes in
//   the cycle after the back sequencer pushes it into the result queue.
//   after reset the grid ram is cleared to unknown one cell a cycle, all
//   GRID_DIM * GRID_DIM cells, while in_full stays high; config writes are
//   taken during that time.
// ----------------------------------------------------------------------------
module occupancy_grid_costmap_fusion_core #(
  parameter int GRID_DIM  = ogf_pkg::GRID_DIM_DEF,
  parameter int LOCAL_DIM = ogf_pkg::LOCAL_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  ogf_pkg::in_t  in_data,
  output logic          in_full,
  output logic          out_empty,
  input  logic          out_pop,
  output ogf_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [23:0]   cfg_wdata
);
  import ogf_pkg::*;

  logic               cmd_pop;
  logic               cmd_empty;
  cmd_t               cmd_head;
  logic               clearing;
  logic               res_push;
  out_t               res_data;
  logic               res_full;
  logic [$bits(out_t)-1:0] res_dout;

  ogf_front #(.GRID_DIM(GRID_DIM), .LOCAL_DIM(LOCAL_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .hold      (clearing),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head)
  );

  ogf_back #(.GRID_DIM(GRID_DIM), .LOCAL_DIM(LOCAL_DIM)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  ogf_fifo #(.WIDTH($bits(out_t))) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_dout)
  );

  assign out_data = out_t'(res_dout);

endmodule
